// ===== hw/rtl/u2fb_pkg.sv =====
package u2fb_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END
  } u2fb_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the new byte into the window
    logic parse;     // decode one sequence at the cursor and advance
    logic show_end;  // present the end transaction
    logic finish;    // commit remaining window, clear on last
  } u2fb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;      // nothing more to decode in the window
    logic last;      // latched last flag of the item in progress
  } u2fb_sts_t;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] POLISH_BASE = 8'hA2;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [1:0] need_of(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if (c >= 8'hF0) r = 2'd3;
    else if (c >= 8'hE0) r = 2'd2;
    else if (c >= 8'hC0) r = 2'd1;
    else if (c == BACKSLASH) r = 2'd1;
    return r;
  endfunction

  // font byte for a code point; bit 8 set when something is produced
  function automatic logic [8:0] map_cp(input logic [20:0] cp);
    logic [8:0] r;
    r = 9'd0;
    if (cp < 21'h80) begin
      r = {1'b1, cp[7:0]};
    end else begin
      case (cp)
        21'h0105: r = {1'b1, POLISH_BASE + 8'd0};
        21'h0107: r = {1'b1, POLISH_BASE + 8'd1};
        21'h0119: r = {1'b1, POLISH_BASE + 8'd2};
        21'h0142: r = {1'b1, POLISH_BASE + 8'd3};
        21'h0144: r = {1'b1, POLISH_BASE + 8'd4};
        21'h00F3: r = {1'b1, POLISH_BASE + 8'd5};
        21'h015B: r = {1'b1, POLISH_BASE + 8'd6};
        21'h017A: r = {1'b1, POLISH_BASE + 8'd7};
        21'h017C: r = {1'b1, POLISH_BASE + 8'd8};
        21'h0104: r = {1'b1, POLISH_BASE + 8'd9};
        21'h0106: r = {1'b1, POLISH_BASE + 8'd10};
        21'h0118: r = {1'b1, POLISH_BASE + 8'd11};
        21'h0141: r = {1'b1, POLISH_BASE + 8'd12};
        21'h0143: r = {1'b1, POLISH_BASE + 8'd13};
        21'h00D3: r = {1'b1, POLISH_BASE + 8'd14};
        21'h015A: r = {1'b1, POLISH_BASE + 8'd15};
        21'h0179: r = {1'b1, POLISH_BASE + 8'd16};
        21'h017B: r = {1'b1, POLISH_BASE + 8'd17};
        21'h2013, 21'h2014: r = {1'b1, 8'h2D};
        21'h2018, 21'h2019: r = {1'b1, 8'h27};
        21'h201C, 21'h201D: r = {1'b1, 8'h22};
        21'h2026: r = {1'b1, 8'h2E};
        default: begin
          if (cp >= 21'hA0 && cp <= 21'hFF) r = {1'b1, cp[7:0]};
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/u2fb_ctrl.sv =====
module u2fb_ctrl
  import u2fb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_busy,
  input  u2fb_sts_t  sts,
  output u2fb_cmd_t  cmd
);

  u2fb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!out_busy && sts.done) state_nxt = sts.last ? ST_END : ST_IDLE;
      end
      ST_END: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.parse = !out_busy && !sts.done;
        cmd.finish = !out_busy && sts.done && !sts.last;
      end
      ST_END: begin
        cmd.show_end = !out_busy;
        cmd.finish = !out_busy;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/u2fb_dp.sv =====
module u2fb_dp
  import u2fb_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 4194304
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  input  u2fb_cmd_t   cmd,
  output u2fb_sts_t   sts,
  output logic        out_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_end,
  output logic [22:0] out_length
);

  localparam logic [22:0] MaxLen = 23'(MAX_LENGTH);

  logic [7:0]  win_r [4];
  logic [2:0]  n_r;
  logic [2:0]  pos_r;
  logic        last_r;
  logic [1:0]  pend_r;
  logic [22:0] prod_r;
  logic        ov_r;
  logic [7:0]  ob_r;
  logic        oe_r;
  logic [22:0] ol_r;

  logic [7:0]  c, b0, b1, b2;
  logic [2:0]  avail;
  logic        stop;
  logic [2:0]  step;
  logic [20:0] cp;
  logic [8:0]  fb;
  logic        esc;

  function automatic logic [7:0] wat(input logic [2:0] p);
    logic [7:0] r;
    r = 8'd0;
    if (p < n_r && p < 3'd4) r = win_r[p[1:0]];
    return r;
  endfunction

  assign out_busy = ov_r && out_stall;
  assign out_valid = ov_r;
  assign out_byte = ob_r;
  assign out_is_end = oe_r;
  assign out_length = ol_r;

  always_comb begin
    c = wat(pos_r);
    b0 = wat(pos_r + 3'd1);
    b1 = wat(pos_r + 3'd2);
    b2 = wat(pos_r + 3'd3);
    avail = n_r - pos_r - 3'd1;
    stop = (pos_r >= n_r) || (!last_r && avail < {1'b0, need_of(c)});
    esc = 1'b0;
    cp = {13'd0, c};
    step = 3'd1;
    if (c == BACKSLASH && avail >= 3'd1 && (b0 == 8'h6E || b0 == 8'h74)) begin
      esc = 1'b1;
      step = 3'd2;
    end else if (c >= 8'hF0 && is_cont(b0) && is_cont(b1) && is_cont(b2)) begin
      cp = {c[2:0], b0[5:0], b1[5:0], b2[5:0]};
      step = 3'd4;
    end else if (c >= 8'hE0 && is_cont(b0) && is_cont(b1)) begin
      cp = {5'd0, c[3:0], b0[5:0], b1[5:0]};
      step = 3'd3;
    end else if (c >= 8'hC0 && is_cont(b0)) begin
      cp = {10'd0, c[4:0], b0[5:0]};
      step = 3'd2;
    end
    fb = esc ? {1'b1, (b0 == 8'h6E) ? 8'h0A : 8'h09} : map_cp(cp);
  end

  assign sts.done = stop;
  assign sts.last = last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_r[pend_r] <= in_byte;
      n_r <= {1'b0, pend_r} + 3'd1;
      pos_r <= 3'd0;
      last_r <= in_last_byte;
    end else if (cmd.parse) begin
      pos_r <= pos_r + step;
    end
    if (cmd.finish && !last_r) begin
      // shift the undecided bytes down to the front of the window
      for (int i = 0; i < 3; i++) win_r[i] <= wat(pos_r + 3'(i));
    end
    if (cmd.parse || cmd.show_end) begin
      ob_r <= cmd.show_end ? 8'd0 : fb[7:0];
      oe_r <= cmd.show_end;
      ol_r <= cmd.show_end ? prod_r : 23'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      prod_r <= 23'd0;
      ov_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        pend_r <= last_r ? 2'd0 : 2'(n_r - pos_r);
        if (last_r) prod_r <= 23'd0;
      end
      if (cmd.parse && fb[8] && prod_r < MaxLen) prod_r <= prod_r + 23'd1;
      if (cmd.show_end || (cmd.parse && fb[8])) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/utf8_to_font_byte_transcoder_unit.sv =====
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_stall   | in_byte[7:0], in_last_byte
// out_    | output    | out_valid/out_stall | out_byte[7:0], out_is_end, out_length[22:0]
//
// An input byte is first loaded, then the decoded sequences in the window are
// walked, then the leftovers are committed; a last byte adds the end
// transaction. The single decode unit walks the window one sequence per cycle
// while the output is not stalled; no new byte is taken until the window is committed.
// rst_n is synchronous; it empties the window and clears the length count.
// A stalled output transaction holds the decoder in place until taken.
module utf8_to_font_byte_transcoder_unit
  import u2fb_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 4194304
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_end,
  output logic [22:0] out_length
);

  u2fb_cmd_t cmd;
  u2fb_sts_t sts;
  logic      out_busy;

  // sequencer: load, walk the window, end transaction
  u2fb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window, decoder, font map and output register
  u2fb_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_busy     (out_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_is_end   (out_is_end),
    .out_length   (out_length)
  );

  // an end transaction carries a zero byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_byte == 8'd0)
    else $error("end transaction with nonzero byte");

  // never decode and load in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.parse))
    else $error("load during decode");

  // no decode step while a result is stalled and the input is not stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !in_stall |-> !cmd.parse)
    else $error("decode while output stalled");

endmodule
